// ===== sv/madt_pkg.sv =====
// types and constants shared by the madt entry parser modules
// no dependencies
`default_nettype none

package madt_pkg;

   // result kinds carried on rsp_tuser
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LAPIC   = 2'd0;
   localparam kind_type KIND_IOAPIC  = 2'd1;
   localparam kind_type KIND_SUMMARY = 2'd2;

   // entry type codes in the table
   localparam logic [7:0] ENTRY_LAPIC  = 8'd0;
   localparam logic [7:0] ENTRY_IOAPIC = 8'd1;

   // shortest entry that holds a whole record
   localparam logic [7:0] LAPIC_REC_LEN  = 8'd8;
   localparam logic [7:0] IOAPIC_REC_LEN = 8'd12;

   // header byte offsets
   localparam logic [31:0] OFS_LEN_LO    = 32'd4;
   localparam logic [31:0] OFS_LEN_HI    = 32'd7;
   localparam logic [31:0] OFS_BASE_LO   = 32'd36;
   localparam logic [31:0] OFS_BASE_HI   = 32'd39;
   localparam logic [31:0] OFS_FLAGS     = 32'd40;
   localparam logic [31:0] OFS_WALK      = 32'd44;

   // entry byte offsets
   localparam logic [7:0] EB_FIRST_ID  = 8'd2;
   localparam logic [7:0] EB_SECOND_ID = 8'd3;
   localparam logic [7:0] EB_W1_LO     = 8'd4;
   localparam logic [7:0] EB_W1_HI     = 8'd7;
   localparam logic [7:0] EB_W2_LO     = 8'd8;
   localparam logic [7:0] EB_W2_HI     = 8'd11;

   localparam int RSP_DATA_W = 136;
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = 2;
   localparam int RSP_CNT_W  = 3;

   // rsp_tdata layout, last member lands in the lowest bits
   typedef struct packed {
      logic [4:0]  pad;
      logic [3:0]  ioapic_total;
      logic [6:0]  lapic_total;
      logic        pcat_compat;
      logic [31:0] local_apic_base;
      logic [31:0] gsi_start;
      logic [31:0] io_apic_address;
      logic        cpu_enabled;
      logic [7:0]  controller_id;
      logic [7:0]  processor_uid;
      logic [5:0]  record_index;
   } rsp_data_type;

   typedef struct packed {
      logic         last;
      kind_type     kind;
      rsp_data_type data;
   } rsp_beat_type;

   // beats produced by one table byte: an optional record, then an optional summary
   typedef struct packed {
      logic         rec_valid;
      rsp_beat_type rec;
      logic         sum_valid;
      rsp_beat_type sum;
   } push_type;

endpackage

`default_nettype wire

// ===== sv/madt_walk.sv =====
// per-byte table state and entry walk of the madt entry parser
// depends on madt_pkg
`default_nettype none

module madt_walk #(
   parameter int MAX_LAPIC  = 64,
   parameter int MAX_IOAPIC = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         byte_in,
   input  wire logic               last_in,
   output madt_pkg::push_type      push
);

   logic [31:0] pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] base_ff, base_in;
   logic        compat_ff, compat_in;
   logic [7:0]  etype_ff, etype_in;
   logic [7:0]  elen_ff, elen_in;
   logic [7:0]  ebp_ff, ebp_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [31:0] w1_ff, w1_in;
   logic [31:0] w2_ff, w2_in;
   logic [6:0]  lapic_ff, lapic_in;
   logic [3:0]  ioapic_ff, ioapic_in;
   logic        stop_ff, stop_in;

   logic [32:0] p_plus2;
   logic [31:0] entry_start;
   logic [32:0] entry_end;
   logic        over_hdr;
   logic        over_ent;

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      base_in   = base_ff;
      compat_in = compat_ff;
      etype_in  = etype_ff;
      elen_in   = elen_ff;
      ebp_in    = ebp_ff;
      first_in  = first_ff;
      second_in = second_ff;
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      lapic_in  = lapic_ff;
      ioapic_in = ioapic_ff;
      stop_in   = stop_ff;
      push      = '0;

      p_plus2     = {1'b0, pos_ff} + 33'd2;
      entry_start = pos_ff - {24'd0, ebp_ff};
      entry_end   = {1'b0, entry_start} + {25'd0, byte_in};
      over_hdr    = p_plus2 > {1'b0, len_ff};
      over_ent    = entry_end > {1'b0, len_ff};

      // header capture
      if (pos_ff >= madt_pkg::OFS_LEN_LO && pos_ff <= madt_pkg::OFS_LEN_HI) begin
         len_in[{pos_ff[1:0], 3'b000} +: 8] = byte_in;
      end else if (pos_ff >= madt_pkg::OFS_BASE_LO && pos_ff <= madt_pkg::OFS_BASE_HI) begin
         base_in[{pos_ff[1:0], 3'b000} +: 8] = byte_in;
      end else if (pos_ff == madt_pkg::OFS_FLAGS) begin
         compat_in = byte_in[0];
      end

      // entry walk
      if (pos_ff >= madt_pkg::OFS_WALK && !stop_ff) begin
         if (ebp_ff == 8'd0) begin
            if (over_hdr) begin
               stop_in = 1'b1;
            end else begin
               etype_in = byte_in;
               ebp_in   = 8'd1;
            end
         end else if (ebp_ff == 8'd1) begin
            if (byte_in == 8'd0 || over_ent) begin
               stop_in = 1'b1;
            end else if (byte_in == 8'd1) begin
               // length one: this byte opens the next entry as its type
               if (over_hdr) begin
                  stop_in = 1'b1;
               end else begin
                  etype_in = madt_pkg::ENTRY_IOAPIC;
                  ebp_in   = 8'd1;
               end
            end else begin
               elen_in = byte_in;
               ebp_in  = (byte_in == 8'd2) ? 8'd0 : 8'd2;
            end
         end else begin
            if (ebp_ff == madt_pkg::EB_FIRST_ID) begin
               first_in = byte_in;
            end else if (ebp_ff == madt_pkg::EB_SECOND_ID) begin
               second_in = byte_in;
            end else if (ebp_ff >= madt_pkg::EB_W1_LO && ebp_ff <= madt_pkg::EB_W1_HI) begin
               w1_in[{ebp_ff[1:0], 3'b000} +: 8] = byte_in;
            end else if (ebp_ff >= madt_pkg::EB_W2_LO && ebp_ff <= madt_pkg::EB_W2_HI) begin
               w2_in[{ebp_ff[1:0], 3'b000} +: 8] = byte_in;
            end

            if (etype_ff == madt_pkg::ENTRY_LAPIC && ebp_ff == madt_pkg::EB_W1_HI
                && elen_ff >= madt_pkg::LAPIC_REC_LEN) begin
               if (lapic_ff < 7'(MAX_LAPIC)) begin
                  push.rec_valid                  = 1'b1;
                  push.rec.kind                   = madt_pkg::KIND_LAPIC;
                  push.rec.data.record_index      = lapic_ff[5:0];
                  push.rec.data.processor_uid     = first_in;
                  push.rec.data.controller_id     = second_in;
                  push.rec.data.cpu_enabled       = w1_in[0];
                  lapic_in                        = lapic_ff + 7'd1;
               end
            end else if (etype_ff == madt_pkg::ENTRY_IOAPIC && ebp_ff == madt_pkg::EB_W2_HI
                         && elen_ff >= madt_pkg::IOAPIC_REC_LEN) begin
               if (ioapic_ff < 4'(MAX_IOAPIC)) begin
                  push.rec_valid                  = 1'b1;
                  push.rec.kind                   = madt_pkg::KIND_IOAPIC;
                  push.rec.data.record_index      = {2'b00, ioapic_ff};
                  push.rec.data.controller_id     = first_in;
                  push.rec.data.io_apic_address   = w1_in;
                  push.rec.data.gsi_start         = w2_in;
                  ioapic_in                       = ioapic_ff + 4'd1;
               end
            end

            ebp_in = ({1'b0, ebp_ff} + 9'd1 >= {1'b0, elen_ff}) ? 8'd0 : ebp_ff + 8'd1;
         end
      end

      // saturating byte counter
      if (pos_ff != '1) begin
         pos_in = pos_ff + 32'd1;
      end

      push.rec.last = !last_in;

      if (last_in) begin
         push.sum_valid                 = 1'b1;
         push.sum.last                  = 1'b1;
         push.sum.kind                  = madt_pkg::KIND_SUMMARY;
         push.sum.data.local_apic_base  = base_in;
         push.sum.data.pcat_compat      = compat_in;
         push.sum.data.lapic_total      = lapic_in;
         push.sum.data.ioapic_total     = ioapic_in;
         pos_in    = '0;
         len_in    = '0;
         base_in   = '0;
         compat_in = 1'b0;
         etype_in  = '0;
         elen_in   = '0;
         ebp_in    = '0;
         first_in  = '0;
         second_in = '0;
         w1_in     = '0;
         w2_in     = '0;
         lapic_in  = '0;
         ioapic_in = '0;
         stop_in   = 1'b0;
      end

      push.rec_valid = push.rec_valid & step;
      push.sum_valid = push.sum_valid & step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         base_ff   <= '0;
         compat_ff <= 1'b0;
         etype_ff  <= '0;
         elen_ff   <= '0;
         ebp_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         w1_ff     <= '0;
         w2_ff     <= '0;
         lapic_ff  <= '0;
         ioapic_ff <= '0;
         stop_ff   <= 1'b0;
      end else if (step) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         base_ff   <= base_in;
         compat_ff <= compat_in;
         etype_ff  <= etype_in;
         elen_ff   <= elen_in;
         ebp_ff    <= ebp_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         w1_ff     <= w1_in;
         w2_ff     <= w2_in;
         lapic_ff  <= lapic_in;
         ioapic_ff <= ioapic_in;
         stop_ff   <= stop_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/madt_rsp_fifo.sv =====
// four-entry result queue, takes up to two beats per cycle, gives one
// depends on madt_pkg
`default_nettype none

module madt_rsp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire madt_pkg::push_type     push,
   output logic                        room,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output madt_pkg::rsp_beat_type      out_beat
);

   madt_pkg::rsp_beat_type mem_ff [madt_pkg::RSP_DEPTH];

   logic [madt_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [madt_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [madt_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic [madt_pkg::RSP_CNT_W-1:0] n_push;
   logic [madt_pkg::RSP_PTR_W-1:0] sum_ptr;
   logic                           pop;

   always_comb begin
      out_valid = count_ff != '0;
      n_push    = madt_pkg::RSP_CNT_W'(push.rec_valid) + madt_pkg::RSP_CNT_W'(push.sum_valid);
      pop       = out_valid && out_ready;
      sum_ptr   = wr_ptr_ff + madt_pkg::RSP_PTR_W'(push.rec_valid);
      wr_ptr_in = wr_ptr_ff + n_push[madt_pkg::RSP_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + madt_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + n_push - madt_pkg::RSP_CNT_W'(pop);
      room      = count_ff <= madt_pkg::RSP_CNT_W'(madt_pkg::RSP_DEPTH - 2);
      out_beat  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.rec_valid) begin
         mem_ff[wr_ptr_ff] <= push.rec;
      end
      if (push.sum_valid) begin
         mem_ff[sum_ptr] <= push.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/madt_entry_parser.sv =====
// top level of the madt entry parser: input register, table walk, result queue
// depends on madt_pkg, madt_walk, madt_rsp_fifo
//
//  channel | dir | tdata                         | tuser        | tlast
//  req     | in  | table_byte                    | -            | end_of_table
//  rsp     | out | record fields, see port note  | record_kind  | run_last
//
// one table byte per cycle while the result queue has room; a byte reaches rsp
// through the input register, then walk logic into the result queue
// the final byte of a table that also completes a record gives two beats;
// the four-entry result queue absorbs them while the next table streams in
// req_tready drops only while the queue has fewer than two free entries and
// a byte waits in the input register, so rsp stalls back up to req
// reset is synchronous, active high, and clears all table and queue state
`default_nettype none

module madt_entry_parser #(
   parameter int MAX_LAPIC  = 64,
   parameter int MAX_IOAPIC = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // table_byte
   input  wire logic                            req_tlast,   // end_of_table

   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // record_index[5:0] processor_uid[13:6] controller_id[21:14] cpu_enabled[22]
   // io_apic_address[54:23] gsi_start[86:55] local_apic_base[118:87]
   // pcat_compat[119] lapic_total[126:120] ioapic_total[130:127], zero above
   output logic [madt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                           rsp_tuser,   // record_kind
   output logic                                 rsp_tlast    // run_last
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                   room;
   logic                   step;
   madt_pkg::push_type     push;
   madt_pkg::rsp_beat_type out_beat;

   // a held byte moves on once the queue can take both of its possible beats
   assign step        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // header capture, entry walk and record building
   madt_walk #(
      .MAX_LAPIC  (MAX_LAPIC),
      .MAX_IOAPIC (MAX_IOAPIC)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_byte_ff),
      .last_in (in_last_ff),
      .push    (push)
   );

   // result queue decouples the two handshakes
   madt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (out_beat)
   );

   assign rsp_tdata = out_beat.data;
   assign rsp_tuser = out_beat.kind;
   assign rsp_tlast = out_beat.last;

endmodule

`default_nettype wire
